>>> hw/rtl/dseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dseq_pkg: shared types and codes for the dual event/signal queue
// Operation and status codes, queue sizing, entry and control structs.
// ----------------------------------------------------------------------------
package dseq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SLOT_W      = 4;

	localparam logic [1:0] OP_PUSH_EVENT  = 2'd0;
	localparam logic [1:0] OP_PUSH_SIGNAL = 2'd1;
	localparam logic [1:0] OP_POP_ANY     = 2'd2;
	localparam logic [1:0] OP_POP_SIGNAL  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic [31:0] payload;
		logic [31:0] listener;
		logic [31:0] id;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic push_ev;
		logic push_sig;
		logic pop_ev;
		logic pop_sig;
		logic load_rd;
		logic load_empty;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       ev_empty;
		logic       sig_empty;
		logic       out_free;
	} dp_stat_t;

	function automatic ptr_t next_slot(input ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_bits(input ptr_t p);
		logic [PTR_W+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, p};
		return ext[SLOT_W-1:0];
	endfunction

endpackage

>>> hw/rtl/dseq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dseq_ctrl: request sequencer
// Accepts one request, picks the queue action, waits for the output register.
// ----------------------------------------------------------------------------
module dseq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  dseq_pkg::dp_stat_t stat,
	output dseq_pkg::dp_cmd_t  cmd
);
	import dseq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		cmd.capture = s_tvalid && (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (stat.op)
					OP_PUSH_EVENT: begin
						if (stat.out_free) begin
							cmd.push_ev = 1'b1;
							state_d     = S_IDLE;
						end
					end
					OP_PUSH_SIGNAL: begin
						if (stat.out_free) begin
							cmd.push_sig = 1'b1;
							state_d      = S_IDLE;
						end
					end
					default: begin
						// event queue wins only on a general pop
						if ((stat.op == OP_POP_ANY) && !stat.ev_empty) begin
							cmd.pop_ev = 1'b1;
							state_d    = S_RD;
						end else if (!stat.sig_empty) begin
							cmd.pop_sig = 1'b1;
							state_d     = S_RD;
						end else if (stat.out_free) begin
							cmd.load_empty = 1'b1;
							state_d        = S_IDLE;
						end
					end
				endcase
			end
			S_RD: begin
				if (stat.out_free) begin
					cmd.load_rd = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

>>> hw/rtl/dseq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dseq_datapath: ring storage, pointers and result register
// Two slot memories with head/tail pointers and one shared registered read port.
// ----------------------------------------------------------------------------
module dseq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  dseq_pkg::dp_cmd_t  cmd,
	output dseq_pkg::dp_stat_t stat,
	input  logic [1:0]         op_in,
	input  dseq_pkg::entry_t   entry_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic               out_sig,
	output dseq_pkg::entry_t   out_entry,
	output logic [dseq_pkg::SLOT_W-1:0] out_slot
);
	import dseq_pkg::*;

	entry_t ev_mem  [QUEUE_DEPTH];
	entry_t sig_mem [QUEUE_DEPTH];

	ptr_t ev_head_q, ev_tail_q, sig_head_q, sig_tail_q;
	logic [1:0] op_q;
	entry_t     in_q;
	entry_t     rd_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic       rd_sig_q;
	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic       out_sig_q;
	entry_t     out_entry_q;
	logic [SLOT_W-1:0] out_slot_q;

	logic ev_full, sig_full, ev_wr, sig_wr, load;

	assign ev_full  = (next_slot(ev_tail_q) == ev_head_q);
	assign sig_full = (next_slot(sig_tail_q) == sig_head_q);
	assign ev_wr    = cmd.push_ev && !ev_full;
	assign sig_wr   = cmd.push_sig && !sig_full;
	assign load     = cmd.push_ev || cmd.push_sig || cmd.load_rd || cmd.load_empty;

	assign stat.op        = op_q;
	assign stat.ev_empty  = (ev_head_q == ev_tail_q);
	assign stat.sig_empty = (sig_head_q == sig_tail_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_sig    = out_sig_q;
	assign out_entry  = out_entry_q;
	assign out_slot   = out_slot_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op_in;
			in_q <= entry_in;
		end
		if (ev_wr) ev_mem[ev_tail_q] <= in_q;
		if (sig_wr) sig_mem[sig_tail_q] <= in_q;
		if (cmd.pop_ev) begin
			rd_q      <= ev_mem[ev_head_q];
			rd_slot_q <= slot_bits(ev_head_q);
			rd_sig_q  <= 1'b0;
		end else if (cmd.pop_sig) begin
			rd_q      <= sig_mem[sig_head_q];
			rd_slot_q <= slot_bits(sig_head_q);
			rd_sig_q  <= 1'b1;
		end
		if (cmd.load_rd) begin
			out_status_q <= ST_OK;
			out_sig_q    <= rd_sig_q;
			out_entry_q  <= rd_q;
			out_slot_q   <= rd_slot_q;
		end else if (load) begin
			// push answers and empty pops carry zero fields
			out_sig_q   <= 1'b0;
			out_entry_q <= '0;
			out_slot_q  <= '0;
			if (cmd.load_empty) out_status_q <= ST_EMPTY;
			else if ((cmd.push_ev && ev_full) || (cmd.push_sig && sig_full))
				out_status_q <= ST_FULL;
			else out_status_q <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_head_q   <= '0;
			ev_tail_q   <= '0;
			sig_head_q  <= '0;
			sig_tail_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ev_wr) ev_tail_q <= next_slot(ev_tail_q);
			if (sig_wr) sig_tail_q <= next_slot(sig_tail_q);
			if (cmd.pop_ev) ev_head_q <= next_slot(ev_head_q);
			if (cmd.pop_sig) sig_head_q <= next_slot(sig_head_q);
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/dual_event_signal_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_event_signal_queue: event and signal ring queues, priority pop
// Push into either queue, pop with event priority or from signals only.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          contents
//  s_*      in   s_tvalid/s_tready  tuser: operation; tdata: id, listener, payload
//  m_*      out  m_tvalid/m_tready  tuser: status, from_signal;
//                                   tdata: id, listener, payload, slot index
//
//  A push result reaches the output register straight from the request
//  register, a pop result from the request register by way of the
//  registered read port of the slot memory.
//  One request is in flight at a time; the next is taken as soon as the
//  result sits in the output register, even while it waits for m_tready.
//  A stall on m_tready holds the sequencer and the next result until free.
//  Reset clears the pointers and the output valid; slot contents are
//  not cleared, no clearing pass is needed.
//
module dual_event_signal_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // id, listener_handle, payload
	input  logic [1:0]   s_tuser,   // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // out_id, out_listener, out_payload, slot_index, pad
	output logic [2:0]   m_tuser    // status, from_signal
);
	import dseq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	entry_t   entry_in;
	entry_t   out_entry;
	logic [1:0] out_status;
	logic       out_sig;
	logic [SLOT_W-1:0] out_slot;

	// unpack the request: first field in the low bits
	assign entry_in.id       = s_tdata[31:0];
	assign entry_in.listener = s_tdata[63:32];
	assign entry_in.payload  = s_tdata[95:64];

	dseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dseq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op_in      (s_tuser),
		.entry_in   (entry_in),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_sig    (out_sig),
		.out_entry  (out_entry),
		.out_slot   (out_slot)
	);

	// pack the result, zero pad to whole bytes
	assign m_tdata = {4'b0000, out_slot, out_entry.payload, out_entry.listener, out_entry.id};
	assign m_tuser = {out_sig, out_status};

endmodule

>>> hw/rtl/dseq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dseq_checker: port-level checks for the dual event/signal queue
// Result encoding and request pacing, bound to the top level.
// ----------------------------------------------------------------------------
module dseq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [95:0]  s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic [2:0]   m_tuser
);
	import dseq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] != 2'd3)
		else $error("undefined status code");

	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == ST_FULL) |-> (m_tdata == '0) && !m_tuser[2])
		else $error("full answer carries data");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == ST_EMPTY) |-> (m_tdata == '0) && !m_tuser[2])
		else $error("empty answer carries data");

endmodule

bind dual_event_signal_queue dseq_checker u_chk (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dual event/signal queue
// Streams push and pop requests into the block through bursty traffic with
// gaps, stalls the result side on shifting patterns plus one long hold-off,
// and checks every result against an in-bench model of both ring queues.
// ----------------------------------------------------------------------------
module tb;
	import dseq_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT  = 200000;
	// A pop passes the request and read registers before the output register; allow slack.
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_AFTER   = 250;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] id;
		logic [31:0] listener;
		logic [31:0] payload;
	} request_t;

	typedef struct {
		logic [1:0]        status;
		logic              from_sig;
		logic [31:0]       id;
		logic [31:0]       listener;
		logic [31:0]       payload;
		logic [SLOT_W-1:0] slot;
	} queue_result_t;

	// Ready patterns for the result side; each lasts a random number of cycles.
	typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [95:0]  s_tdata  = '0;
	logic [1:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [2:0]   m_tuser;

	dual_event_signal_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	request_t      pending_requests[$];
	queue_result_t expected_results[$];

	// Model copy of both rings; only slots between head and tail are ever read.
	entry_t event_ring[QUEUE_DEPTH];
	entry_t signal_ring[QUEUE_DEPTH];
	int     ev_head  = 0;
	int     ev_tail  = 0;
	int     sig_head = 0;
	int     sig_tail = 0;

	int error_count    = 0;
	int requests_taken = 0;
	int results_seen   = 0;
	int cycle_count    = 0;
	int n_push_ok      = 0;
	int n_push_full    = 0;
	int n_pop_event    = 0;
	int n_pop_signal   = 0;
	int n_pop_empty    = 0;

	bit       req_taken  = 1'b0;
	int       gap_left   = 0;
	int       burst_left = 0;
	int       hold_left  = 0;
	bit       hold_done  = 1'b0;
	int       mode_left  = 0;
	rx_mode_e rx_mode    = RX_ALWAYS;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hold reset for a fixed number of cycles, release once, away from the edge.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Run-length guard: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Advance the model by one request and return the result it must produce.
	// Pushes return all-zero fields apart from status; an empty pop likewise.
	function automatic queue_result_t queue_model_step(input request_t r);
		queue_result_t res;
		entry_t        e;
		bit            popped;
		res.status   = ST_OK;
		res.from_sig = 1'b0;
		res.id       = '0;
		res.listener = '0;
		res.payload  = '0;
		res.slot     = '0;
		popped       = 1'b0;
		e.id         = r.id;
		e.listener   = r.listener;
		e.payload    = r.payload;
		case (r.op)
			OP_PUSH_EVENT: begin
				// Full when the tail sits one slot behind the head: nothing moves.
				if ((ev_tail + 1) % QUEUE_DEPTH == ev_head) begin
					res.status = ST_FULL;
					n_push_full++;
				end else begin
					event_ring[ev_tail] = e;
					ev_tail = (ev_tail + 1) % QUEUE_DEPTH;
					n_push_ok++;
				end
			end
			OP_PUSH_SIGNAL: begin
				if ((sig_tail + 1) % QUEUE_DEPTH == sig_head) begin
					res.status = ST_FULL;
					n_push_full++;
				end else begin
					signal_ring[sig_tail] = e;
					sig_tail = (sig_tail + 1) % QUEUE_DEPTH;
					n_push_ok++;
				end
			end
			default: begin
				// Events win on a general pop; a signal pop never looks at events.
				if (r.op == OP_POP_ANY && ev_head != ev_tail) begin
					e        = event_ring[ev_head];
					res.slot = SLOT_W'(ev_head);
					ev_head  = (ev_head + 1) % QUEUE_DEPTH;
					popped   = 1'b1;
					n_pop_event++;
				end else if (sig_head != sig_tail) begin
					e            = signal_ring[sig_head];
					res.slot     = SLOT_W'(sig_head);
					res.from_sig = 1'b1;
					sig_head     = (sig_head + 1) % QUEUE_DEPTH;
					popped       = 1'b1;
					n_pop_signal++;
				end else begin
					res.status = ST_EMPTY;
					n_pop_empty++;
				end
				if (popped) begin
					res.id       = e.id;
					res.listener = e.listener;
					res.payload  = e.payload;
				end
			end
		endcase
		return res;
	endfunction

	function automatic void add_request(input logic [1:0] op, input logic [31:0] id,
			input logic [31:0] listener, input logic [31:0] payload);
		request_t r;
		r.op       = op;
		r.id       = id;
		r.listener = listener;
		r.payload  = payload;
		pending_requests.push_back(r);
	endfunction

	// Mostly random words, with the all-zero and all-one extremes mixed in.
	function automatic logic [31:0] data_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 32'h0000_0000;
		else if (pick == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= REPORT_MAX)
				$display("Mismatch on result %0d, %s: expected %h, got %h", results_seen,
					field, want, got);
		end
	endtask

	// Driver: present the next request at the falling edge once the current one
	// has been taken; insert random gaps between bursts of random length.
	always @(negedge clk) begin : driver
		request_t r;
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (pending_requests.size() > 0) begin
				r = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= r.op;
				s_tdata  <= {r.payload, r.listener, r.id};
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switch between ready patterns, and once, after enough requests
	// have gone in, drop ready for a long stretch so the block backs up.
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (!hold_done && requests_taken >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(10, 60);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Monitor: at the rising edge, feed accepted requests to the model and
	// check each accepted result against the oldest expectation.
	always @(posedge clk) begin : monitor
		request_t      r;
		queue_result_t want;
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				r.op       = s_tuser;
				r.id       = s_tdata[31:0];
				r.listener = s_tdata[63:32];
				r.payload  = s_tdata[95:64];
				expected_results.push_back(queue_model_step(r));
				requests_taken++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("Result %0d arrived with nothing expected: tuser %h tdata %h",
							results_seen, m_tuser, m_tdata);
				end else begin
					want = expected_results.pop_front();
					compare_field("status", 32'(want.status), 32'(m_tuser[1:0]));
					compare_field("from_signal", 32'(want.from_sig), 32'(m_tuser[2]));
					compare_field("id", want.id, m_tdata[31:0]);
					compare_field("listener", want.listener, m_tdata[63:32]);
					compare_field("payload", want.payload, m_tdata[95:64]);
					compare_field("slot_index", 32'(want.slot), 32'(m_tdata[99:96]));
				end
			end
		end
	end

	initial begin : stimulus
		int          n;
		int          len;
		int          push_pct;
		int          sig_pct;
		logic [1:0]  op;

		// Directed: empty pops, extreme field values, priority and fallback.
		add_request(OP_POP_ANY, 32'h0, 32'h0, 32'h0);
		add_request(OP_POP_SIGNAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(OP_PUSH_EVENT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_request(OP_PUSH_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(OP_PUSH_SIGNAL, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		add_request(OP_PUSH_SIGNAL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_A5A5);
		add_request(OP_POP_SIGNAL, 32'h0, 32'h0, 32'h0);  // skips the queued events
		add_request(OP_POP_ANY, 32'h0, 32'h0, 32'h0);     // event first
		add_request(OP_POP_ANY, 32'h0, 32'h0, 32'h0);
		add_request(OP_POP_ANY, 32'h0, 32'h0, 32'h0);     // falls back to signals
		add_request(OP_POP_SIGNAL, 32'h0, 32'h0, 32'h0);  // both empty
		add_request(OP_POP_ANY, 32'h0, 32'h0, 32'h0);

		// Random phases: push-heavy phases fill the rings to full, pop-heavy
		// phases drain them to empty, mixed phases wrap the pointers.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			push_pct = 15 + 35 * $urandom_range(0, 2);
			sig_pct  = $urandom_range(10, 90);
			len      = $urandom_range(20, 70);
			if (len > RANDOM_ITEMS - n)
				len = RANDOM_ITEMS - n;
			repeat (len) begin
				if ($urandom_range(1, 100) <= push_pct)
					op = ($urandom_range(1, 100) <= sig_pct) ? OP_PUSH_SIGNAL : OP_PUSH_EVENT;
				else
					op = $urandom_range(0, 1) ? OP_POP_ANY : OP_POP_SIGNAL;
				add_request(op, data_word(), data_word(), data_word());
			end
			n += len;
		end

		// Drain: every request taken and every result back, then settle.
		do
			@(posedge clk);
		while (!arst_n || pending_requests.size() != 0 || s_tvalid ||
			expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		error_count += expected_results.size();

		$display("Ran %0d requests: %0d pushes stored, %0d refused as full, %0d event pops,",
			requests_taken, n_push_ok, n_push_full, n_pop_event);
		$display("%0d signal pops, %0d empty pops; %0d results checked, one %0d-cycle hold-off.",
			n_pop_signal, n_pop_empty, results_seen, HOLD_CYCLES);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dseq_pkg.sv
hw/rtl/dseq_ctrl.sv
hw/rtl/dseq_datapath.sv
hw/rtl/dual_event_signal_queue.sv
hw/rtl/dseq_checker.sv
sim/tb.sv
